// ===== rtl/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm_pkg: shared types and constants of the bmp dominant color meter
// Holds the result codes, the bmp layout constants, the job that goes from
// the parser to the result unit, and the queue status.
// ----------------------------------------------------------------------------
package dcm_pkg;

   // default bounds
   localparam int DEF_MAX_DIM     = 4096;
   localparam int DEF_MAX_PALETTE = 256;

   // port widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;
   localparam int OUT_DIM_W  = 13;
   localparam int SUM_W      = 32;

   // bmp layout
   localparam int HDR_BYTES  = 54;
   localparam int WIDTH_OFS  = 18;
   localparam int HEIGHT_OFS = 22;
   localparam int PAL_OFS    = 46;
   localparam int FIELD_BYTES = 4;
   localparam int ROW_ALIGN  = 4;
   localparam int ALIGN_W    = $clog2(ROW_ALIGN);

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TRUNC   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_TOO_BIG = 2'd3;

   // dominant channel codes
   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   // job queue depth (power of two)
   localparam int QUEUE_DEPTH = 2;

   // one finished image as handed to the result unit
   typedef struct packed {
      logic [1:0]           status;
      logic [SUM_W-1:0]     red_sum;
      logic [SUM_W-1:0]     green_sum;
      logic [SUM_W-1:0]     blue_sum;
      logic [SUM_W-1:0]     pixels;
      logic [OUT_DIM_W-1:0] width;
      logic [OUT_DIM_W-1:0] height;
   } job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// ===== rtl/dcm_front.sv =====
// ----------------------------------------------------------------------------
// dcm_front: bmp byte parser
// Walks header, palette, pixel and padding bytes, keeps the channel sums and
// pushes one job per file into the queue when a result is due.
// ----------------------------------------------------------------------------
module dcm_front #(
   parameter int MAX_DIM     = dcm_pkg::DEF_MAX_DIM,
   parameter int MAX_PALETTE = dcm_pkg::DEF_MAX_PALETTE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [dcm_pkg::REQ_DATA_W-1:0]  data_byte,
   input  logic                            last_byte,
   output logic                            push,
   output dcm_pkg::job_type                push_job
);
   import dcm_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int PAL_W = (MAX_PALETTE > 0) ? $clog2(MAX_PALETTE + 1) : 1;
   localparam int CNT_W = (PAL_W + 2 > 6) ? PAL_W + 2 : 6;
   localparam logic [31:0] MAX_DIM_32 = 32'(MAX_DIM);
   localparam logic [31:0] MAX_PAL_32 = 32'(MAX_PALETTE);

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_PALETTE = 3'd1;
   localparam logic [2:0] PH_PIXELS  = 3'd2;
   localparam logic [2:0] PH_PAD     = 3'd3;
   localparam logic [2:0] PH_DRAIN   = 3'd4;

   localparam logic [1:0] LAST_CHANNEL = 2'd2;

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      width_ff, width_in;
   logic [31:0]      height_ff, height_in;
   logic [31:0]      palette_ff, palette_in;
   logic [1:0]       chan_ff, chan_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] red_ff, red_in;
   logic [SUM_W-1:0] green_ff, green_in;
   logic [SUM_W-1:0] blue_ff, blue_in;
   logic [2*DIM_W-1:0] prod_ff, prod_in;

   logic             emit;
   logic [1:0]       lane;
   logic [CNT_W-1:0] cnt_next;
   logic [CNT_W-1:0] pal_bytes;
   logic [DIM_W-1:0] col_next;
   logic [DIM_W-1:0] row_next;
   logic             end_row;

   // pixel count from the captured header, settled long before any pixel
   assign prod_in = width_ff[DIM_W-1:0] * height_ff[DIM_W-1:0];

   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign pal_bytes = CNT_W'(palette_ff[PAL_W-1:0]) * CNT_W'(3);
   assign col_next  = col_ff + DIM_W'(1);
   assign row_next  = row_ff + DIM_W'(1);

   // parser next state
   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      palette_in = palette_ff;
      chan_in    = chan_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      emit       = 1'b0;
      end_row    = 1'b0;
      lane       = 2'd0;
      push_job   = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            // capture the little-endian header fields
            if (cnt_ff >= CNT_W'(WIDTH_OFS) && cnt_ff < CNT_W'(WIDTH_OFS + FIELD_BYTES)) begin
               lane = 2'(cnt_ff - CNT_W'(WIDTH_OFS));
               width_in[8*lane +: 8] = width_ff[8*lane +: 8] | data_byte;
            end else if (cnt_ff >= CNT_W'(HEIGHT_OFS) &&
                         cnt_ff < CNT_W'(HEIGHT_OFS + FIELD_BYTES)) begin
               lane = 2'(cnt_ff - CNT_W'(HEIGHT_OFS));
               height_in[8*lane +: 8] = height_ff[8*lane +: 8] | data_byte;
            end else if (cnt_ff >= CNT_W'(PAL_OFS) && cnt_ff < CNT_W'(PAL_OFS + FIELD_BYTES)) begin
               lane = 2'(cnt_ff - CNT_W'(PAL_OFS));
               palette_in[8*lane +: 8] = palette_ff[8*lane +: 8] | data_byte;
            end
            cnt_in = cnt_next;
            // header done: check the bounds
            if (cnt_next >= CNT_W'(HDR_BYTES)) begin
               cnt_in = '0;
               if (width_in == 32'd0 || height_in == 32'd0) begin
                  emit = 1'b1;
                  push_job.status = STATUS_EMPTY;
               end else if (width_in > MAX_DIM_32 || height_in > MAX_DIM_32 ||
                            palette_in > MAX_PAL_32) begin
                  emit = 1'b1;
                  push_job.status = STATUS_TOO_BIG;
               end else if (palette_in != 32'd0) begin
                  phase_in = PH_PALETTE;
               end else begin
                  phase_in = PH_PIXELS;
               end
            end
         end
         PH_PALETTE: begin
            cnt_in = cnt_next;
            if (cnt_next >= pal_bytes) begin
               cnt_in   = '0;
               phase_in = PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            // bytes come as blue, green, red
            unique case (chan_ff)
               2'd0:    blue_in  = blue_ff + SUM_W'(data_byte);
               2'd1:    green_in = green_ff + SUM_W'(data_byte);
               default: red_in   = red_ff + SUM_W'(data_byte);
            endcase
            chan_in = chan_ff + 2'd1;
            if (chan_ff >= LAST_CHANNEL) begin
               chan_in = 2'd0;
               col_in  = col_next;
               if (col_next >= width_ff[DIM_W-1:0]) begin
                  col_in = '0;
                  if (width_ff[ALIGN_W-1:0] != '0) begin
                     cnt_in   = '0;
                     phase_in = PH_PAD;
                  end else begin
                     end_row = 1'b1;
                  end
               end
            end
         end
         PH_PAD: begin
            cnt_in = cnt_next;
            if (cnt_next >= CNT_W'(width_ff[ALIGN_W-1:0])) begin
               cnt_in  = '0;
               end_row = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // row finished: next row or the image result
      if (end_row) begin
         row_in   = row_next;
         phase_in = PH_PIXELS;
         if (row_next >= height_ff[DIM_W-1:0]) begin
            emit = 1'b1;
            push_job.status = STATUS_OK;
         end
      end

      if (emit) begin
         phase_in = PH_DRAIN;
      end

      // job payload from the values this byte leaves
      push_job.red_sum   = red_in;
      push_job.green_sum = green_in;
      push_job.blue_sum  = blue_in;
      push_job.pixels    = SUM_W'(prod_ff);
      push_job.width     = (width_in > MAX_DIM_32) ? MAX_DIM_32[OUT_DIM_W-1:0]
                                                    : width_in[OUT_DIM_W-1:0];
      push_job.height    = (height_in > MAX_DIM_32) ? MAX_DIM_32[OUT_DIM_W-1:0]
                                                     : height_in[OUT_DIM_W-1:0];

      // end of file: early end is flagged, then the parser rearms
      if (last_byte) begin
         if (!emit && phase_ff != PH_DRAIN) begin
            emit = 1'b1;
            push_job.status = STATUS_TRUNC;
         end
         phase_in   = PH_HEADER;
         cnt_in     = '0;
         width_in   = '0;
         height_in  = '0;
         palette_in = '0;
         chan_in    = '0;
         col_in     = '0;
         row_in     = '0;
         red_in     = '0;
         green_in   = '0;
         blue_in    = '0;
      end
   end

   assign push = accept & emit;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         cnt_ff     <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         palette_ff <= '0;
         chan_ff    <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         red_ff     <= '0;
         green_ff   <= '0;
         blue_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         palette_ff <= palette_in;
         chan_ff    <= chan_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
      end
   end

   // pixel count register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/dcm_fifo.sv =====
// ----------------------------------------------------------------------------
// dcm_fifo: job queue
// Short first-in first-out queue of finished image jobs between the parser
// and the result unit.
// ----------------------------------------------------------------------------
module dcm_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dcm_pkg::job_type        push_job,
   input  logic                    pop,
   output dcm_pkg::job_type        pop_job,
   output dcm_pkg::fifo_stat_type  stat
);
   import dcm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_job    = mem_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/dcm_back.sv =====
// ----------------------------------------------------------------------------
// dcm_back: result unit
// Takes one job from the queue, picks the dominant channel, divides its sum
// by the pixel count one quotient bit per cycle and holds the response.
// ----------------------------------------------------------------------------
module dcm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  dcm_pkg::fifo_stat_type           q_stat,
   input  dcm_pkg::job_type                 pop_job,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       status,
   output logic [1:0]                       dominant_channel,
   output logic [7:0]                       channel_average,
   output logic [dcm_pkg::OUT_DIM_W-1:0]    image_width,
   output logic [dcm_pkg::OUT_DIM_W-1:0]    image_height
);
   import dcm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SEL  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;
   localparam logic [1:0] B_OUT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   job_type              job_ff, job_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [1:0]           status_ff, status_in;
   logic [1:0]           chan_ff, chan_in;
   logic [7:0]           avg_ff, avg_in;
   logic [OUT_DIM_W-1:0] width_ff, width_in;
   logic [OUT_DIM_W-1:0] height_ff, height_in;

   logic [SUM_W:0]       rem_shift;
   logic                 fits;

   // one restoring division step
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign fits      = (rem_shift >= {1'b0, job_ff.pixels});

   assign pop = (state_ff == B_IDLE) && !q_stat.empty;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      status_in = status_ff;
      chan_in   = chan_ff;
      avg_in    = avg_ff;
      width_in  = width_ff;
      height_in = height_ff;

      unique case (state_ff)
         B_IDLE: begin
            // take a job; error results carry zero channel and average
            if (!q_stat.empty) begin
               job_in    = pop_job;
               status_in = pop_job.status;
               width_in  = pop_job.width;
               height_in = pop_job.height;
               chan_in   = CHAN_RED;
               avg_in    = 8'd0;
               state_in  = (pop_job.status == STATUS_OK) ? B_SEL : B_OUT;
            end
         end
         B_SEL: begin
            // red wins ties, then green beats blue
            rem_in  = '0;
            step_in = '0;
            if (job_ff.red_sum >= job_ff.green_sum && job_ff.red_sum >= job_ff.blue_sum) begin
               chan_in = CHAN_RED;
               quo_in  = job_ff.red_sum;
            end else if (job_ff.green_sum >= job_ff.blue_sum) begin
               chan_in = CHAN_GREEN;
               quo_in  = job_ff.green_sum;
            end else begin
               chan_in = CHAN_BLUE;
               quo_in  = job_ff.blue_sum;
            end
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in  = fits ? SUM_W'(rem_shift - {1'b0, job_ff.pixels}) : rem_shift[SUM_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               avg_in   = quo_in[7:0];
               state_in = B_OUT;
            end
         end
         default: begin
            // hold the response until it is taken
            if (rsp_ready) begin
               state_in = B_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath and response registers
   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      status_ff <= status_in;
      chan_ff   <= chan_in;
      avg_ff    <= avg_in;
      width_ff  <= width_in;
      height_ff <= height_in;
   end

   assign rsp_valid        = (state_ff == B_OUT);
   assign status           = status_ff;
   assign dominant_channel = chan_ff;
   assign channel_average  = avg_ff;
   assign image_width      = width_ff;
   assign image_height     = height_ff;

endmodule

// ===== rtl/bmp_dominant_color_meter.sv =====
// Result path: an error result goes from the parser through the job queue to
//   the response; a good image also takes channel select plus 32 steps of
//   the shared bit-serial divider in the result unit.
// Throughput: one request byte per cycle while the two-entry job queue has room;
//   the result unit takes one job at a time.
// Reset: synchronous, active high; parser, queue and result unit return to idle.
// ----------------------------------------------------------------------------
// bmp_dominant_color_meter: top level
// Parses a 24-bit bmp byte stream and reports its dominant color channel
// and that channel's mean over all pixels.
// ----------------------------------------------------------------------------
module bmp_dominant_color_meter #(
   parameter int MAX_DIM     = dcm_pkg::DEF_MAX_DIM,
   parameter int MAX_PALETTE = dcm_pkg::DEF_MAX_PALETTE
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: data_byte[7:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dcm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: dominant_channel[1:0], channel_average[9:2], image_width[22:10],
   //            image_height[35:23], zero fill[39:36]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dcm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [dcm_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import dcm_pkg::*;

   logic          accept;
   logic          push;
   logic          pop;
   job_type       push_job;
   job_type       pop_job;
   fifo_stat_type q_stat;

   logic [1:0]           status;
   logic [1:0]           dominant_channel;
   logic [7:0]           channel_average;
   logic [OUT_DIM_W-1:0] image_width;
   logic [OUT_DIM_W-1:0] image_height;

   // request side stalls only on a full queue
   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid & req_tready;

   dcm_front #(
      .MAX_DIM     (MAX_DIM),
      .MAX_PALETTE (MAX_PALETTE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .push      (push),
      .push_job  (push_job)
   );

   dcm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .stat     (q_stat)
   );

   dcm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .pop_job          (pop_job),
      .pop              (pop),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .status           (status),
      .dominant_channel (dominant_channel),
      .channel_average  (channel_average),
      .image_width      (image_width),
      .image_height     (image_height)
   );

   // response packing
   assign rsp_tdata = {4'd0, image_height, image_width, channel_average, dominant_channel};
   assign rsp_tuser = status;

endmodule

// ===== rtl/dcm_checker.sv =====
// ----------------------------------------------------------------------------
// dcm_checker: port checks of the bmp dominant color meter
// Watches the top-level ports over time and flags broken responses.
// ----------------------------------------------------------------------------
module dcm_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [dcm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [dcm_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import dcm_pkg::*;

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // error responses carry zero channel and average
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[9:0] == 10'd0)
      else $error("error response with nonzero channel or average");

   // channel code is red, green or blue
   a_chan_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] == CHAN_RED || rsp_tdata[1:0] == CHAN_GREEN ||
                     rsp_tdata[1:0] == CHAN_BLUE)
      else $error("bad dominant channel code");

   // the result unit is idle in the cycle after each delivered response
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("response back to back from result unit");

endmodule

bind bmp_dominant_color_meter dcm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
